### hdl/jsu_pkg.sv
// Shared types, codes and helper functions for the JSON string unescaper.
package jsu_pkg;

    // Parser mode codes
    localparam logic [2:0] MODE_TEXT   = 3'd0;
    localparam logic [2:0] MODE_ESC    = 3'd1;
    localparam logic [2:0] MODE_HEX    = 3'd2;
    localparam logic [2:0] MODE_WANTBS = 3'd3;
    localparam logic [2:0] MODE_WANTU  = 3'd4;
    localparam logic [2:0] MODE_HEX2   = 3'd5;

    // Status codes
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_CTRL = 2'd1;
    localparam logic [1:0] ST_ESC  = 2'd2;
    localparam logic [1:0] ST_UTF8 = 2'd3;

    // Characters of interest
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LC_B   = 8'h62;
    localparam logic [7:0] CH_LC_F   = 8'h66;
    localparam logic [7:0] CH_LC_N   = 8'h6E;
    localparam logic [7:0] CH_LC_R   = 8'h72;
    localparam logic [7:0] CH_LC_T   = 8'h74;
    localparam logic [7:0] CH_LC_U   = 8'h75;
    localparam logic [7:0] CTRL_MAX  = 8'h1F;

    // UTF-8 checker state
    typedef struct packed {
        logic        bad;
        logic [1:0]  trail;
        logic [20:0] code;
        logic [1:0]  len;
    } t_utf8;

    // Up to four encoded bytes
    typedef struct packed {
        logic [2:0]      n;
        logic [3:0][7:0] b;
    } t_enc;

    // Hex digit decode: bit 4 set when the character is a digit
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) r = {1'b1, 4'(c - 8'h30)};
        else if (c >= 8'h61 && c <= 8'h66) r = {1'b1, 4'(c - 8'h57)};
        else if (c >= 8'h41 && c <= 8'h46) r = {1'b1, 4'(c - 8'h37)};
        return r;
    endfunction

    // Code point to UTF-8 bytes
    function automatic t_enc put_code(input logic [20:0] v);
        t_enc e;
        e = '0;
        if (v <= 21'h7F) begin
            e.n    = 3'd1;
            e.b[0] = v[7:0];
        end else if (v <= 21'h7FF) begin
            e.n    = 3'd2;
            e.b[0] = {3'b110, v[10:6]};
            e.b[1] = {2'b10, v[5:0]};
        end else if (v <= 21'hFFFF) begin
            e.n    = 3'd3;
            e.b[0] = {4'b1110, v[15:12]};
            e.b[1] = {2'b10, v[11:6]};
            e.b[2] = {2'b10, v[5:0]};
        end else begin
            e.n    = 3'd4;
            e.b[0] = {5'b11110, v[20:18]};
            e.b[1] = {2'b10, v[17:12]};
            e.b[2] = {2'b10, v[11:6]};
            e.b[3] = {2'b10, v[5:0]};
        end
        return e;
    endfunction

    // One byte through the UTF-8 checker
    function automatic t_utf8 utf8_step(input t_utf8 s, input logic [7:0] b);
        t_utf8      r;
        logic [1:0] w;
        r = s;
        w = 2'd0;
        if (!s.bad) begin
            if (s.trail == 2'd0) begin
                if (b < 8'h80) begin
                    r = s;
                end else if (b < 8'd194) begin
                    r.bad   = 1'b1;
                    r.trail = 2'd0;
                end else if (b < 8'd224) begin
                    r.len   = 2'd1;
                    r.code  = {16'd0, b[4:0]};
                    r.trail = 2'd1;
                end else if (b < 8'd240) begin
                    r.len   = 2'd2;
                    r.code  = {17'd0, b[3:0]};
                    r.trail = 2'd2;
                end else if (b <= 8'd244) begin
                    r.len   = 2'd3;
                    r.code  = {18'd0, b[2:0]};
                    r.trail = 2'd3;
                end else begin
                    r.bad   = 1'b1;
                    r.trail = 2'd0;
                end
            end else if (b[7:6] != 2'b10) begin
                r.bad   = 1'b1;
                r.trail = 2'd0;
            end else begin
                r.code  = {s.code[14:0], b[5:0]};
                r.trail = s.trail - 2'd1;
                if (r.trail == 2'd0) begin
                    if (r.code <= 21'h7F) w = 2'd0;
                    else if (r.code <= 21'h7FF) w = 2'd1;
                    else if (r.code <= 21'hFFFF) w = 2'd2;
                    else w = 2'd3;
                    if (r.code > 21'h10FFFF ||
                        (r.code >= 21'hD800 && r.code <= 21'hDFFF) ||
                        w != s.len) begin
                        r.bad   = 1'b1;
                        r.trail = 2'd0;
                    end
                end
            end
        end
        return r;
    endfunction

endpackage

### hdl/json_string_unescaper_core.sv
// JSON string body unescaper with UTF-8 output check, top level.
//
//  channel | direction | handshake                   | payload
//  --------+-----------+-----------------------------+------------------------------------
//  in      | input     | i_in_valid / o_in_stall     | i_in_byte, i_end_of_string
//  out     | output    | o_out_valid / i_out_stall   | o_out_byte, o_byte_valid, o_last,
//          |           |                             | o_status
//
//  An input byte is registered, decoded combinationally and its 0..4 results are loaded
//  as one bundle into the result register, which drains one result per cycle while
//  i_out_stall is low. A byte with no result moves on without waiting for the result
//  register; a byte with results waits until the previous bundle has drained, since
//  the result register takes one bundle at a time.
//  Reset is synchronous, active low, and clears parser, checker and handshake state.
//  An output stall holds the result register and backs up into o_in_stall.
module json_string_unescaper_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_end_of_string,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_byte_valid,
    output logic       o_last,
    output logic [1:0] o_status
);
    import jsu_pkg::*;

    // Input register
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_eos;

    // Parser and checker state
    logic [2:0]  r_mode, n_mode;
    logic [15:0] r_hex, n_hex;
    logic [1:0]  r_dcnt, n_dcnt;
    logic [9:0]  r_hsur, n_hsur;
    logic        r_saw, n_saw;
    logic [1:0]  r_err, n_err;
    t_utf8       r_utf8, n_utf8;

    // Result bundle register
    logic            r_rvld;
    logic [3:0][7:0] r_rb;
    logic            r_rbv;
    logic            r_rlast;
    logic [1:0]      r_rstat;
    logic [1:0]      r_rcnt;
    logic [1:0]      r_ridx;

    // Decode outputs
    logic [3:0][7:0] em_b;
    logic [2:0]      em_n;
    logic [2:0]      res_n;
    t_enc            cand;
    logic [20:0]     code_v;
    logic            do_code;
    logic [4:0]      hd;
    logic [15:0]     nh;
    logic            bad0;

    logic in_xfer, out_xfer, fire, bundle_free;

    // Decode of one byte: parse, encode, check
    always_comb begin
        n_mode  = r_mode;
        n_hex   = r_hex;
        n_dcnt  = r_dcnt;
        n_hsur  = r_hsur;
        n_saw   = r_saw;
        n_err   = r_err;
        n_utf8  = r_utf8;
        cand    = '0;
        code_v  = '0;
        do_code = 1'b0;
        hd      = hex_digit(r_in_byte);
        nh      = {r_hex[11:0], hd[3:0]};
        em_b    = '0;
        em_n    = 3'd0;
        bad0    = 1'b0;

        if (r_err == ST_OK) begin
            case (r_mode)
                MODE_TEXT: begin
                    if (r_in_byte <= CTRL_MAX) begin
                        n_err = ST_CTRL;
                    end else if (r_in_byte == CH_BSLASH) begin
                        n_saw  = 1'b1;
                        if (r_utf8.bad) n_err = ST_UTF8;
                        n_mode = MODE_ESC;
                    end else begin
                        cand.n    = 3'd1;
                        cand.b[0] = r_in_byte;
                    end
                end
                MODE_ESC: begin
                    n_mode = MODE_TEXT;
                    cand.n = 3'd1;
                    case (r_in_byte)
                        CH_QUOTE, CH_BSLASH, CH_SLASH: cand.b[0] = r_in_byte;
                        CH_LC_B: cand.b[0] = 8'h08;
                        CH_LC_F: cand.b[0] = 8'h0C;
                        CH_LC_N: cand.b[0] = 8'h0A;
                        CH_LC_R: cand.b[0] = 8'h0D;
                        CH_LC_T: cand.b[0] = 8'h09;
                        CH_LC_U: begin
                            cand.n = 3'd0;
                            n_mode = MODE_HEX;
                            n_hex  = '0;
                            n_dcnt = 2'd0;
                        end
                        default: begin
                            cand.n = 3'd0;
                            n_err  = ST_ESC;
                        end
                    endcase
                end
                MODE_WANTBS: begin
                    if (r_in_byte != CH_BSLASH) n_err = ST_ESC;
                    else n_mode = MODE_WANTU;
                end
                MODE_WANTU: begin
                    if (r_in_byte != CH_LC_U) begin
                        n_err = ST_ESC;
                    end else begin
                        n_mode = MODE_HEX2;
                        n_hex  = '0;
                        n_dcnt = 2'd0;
                    end
                end
                MODE_HEX, MODE_HEX2: begin
                    if (!hd[4]) begin
                        n_err = ST_ESC;
                    end else begin
                        n_hex = nh;
                        if (r_dcnt != 2'd3) begin
                            n_dcnt = r_dcnt + 2'd1;
                        end else begin
                            n_dcnt = 2'd0;
                            if (r_mode == MODE_HEX2) begin
                                if (nh >= 16'hDC00 && nh <= 16'hDFFF) begin
                                    code_v  = {1'b0, r_hsur, nh[9:0]} + 21'h010000;
                                    do_code = 1'b1;
                                    n_mode  = MODE_TEXT;
                                end else begin
                                    n_err = ST_ESC;
                                end
                            end else if (nh >= 16'hD800 && nh <= 16'hDBFF) begin
                                n_hsur = nh[9:0];
                                n_mode = MODE_WANTBS;
                            end else begin
                                code_v  = {5'd0, nh};
                                do_code = 1'b1;
                                n_mode  = MODE_TEXT;
                            end
                        end
                    end
                end
                default: n_mode = MODE_TEXT;
            endcase
        end

        if (do_code) cand = put_code(code_v);

        // Each candidate byte passes the UTF-8 check; bytes after an error are dropped
        for (int k = 0; k < 4; k++) begin
            if (3'(k) < cand.n) begin
                bad0   = n_utf8.bad;
                n_utf8 = utf8_step(n_utf8, cand.b[k]);
                if (!bad0 && n_utf8.bad && r_saw && n_err == ST_OK) n_err = ST_UTF8;
                if (n_err == ST_OK) begin
                    em_b[k] = cand.b[k];
                    em_n    = 3'(k + 1);
                end
            end
        end

        // End of string checks
        if (r_in_eos) begin
            if (n_err == ST_OK && n_mode != MODE_TEXT && n_mode != MODE_WANTBS)
                n_err = ST_ESC;
            if (n_err == ST_OK && n_saw && (n_utf8.bad || n_utf8.trail != 2'd0))
                n_err = ST_UTF8;
        end

        res_n = (r_in_eos && em_n == 3'd0) ? 3'd1 : em_n;
    end

    // Handshakes
    assign out_xfer    = r_rvld && !i_out_stall;
    assign bundle_free = !r_rvld || (out_xfer && r_ridx == r_rcnt);
    assign fire        = r_in_vld && (res_n == 3'd0 || bundle_free);
    assign o_in_stall  = r_in_vld && !fire;
    assign in_xfer     = i_in_valid && !o_in_stall;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_xfer) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
        if (in_xfer) begin
            r_in_byte <= i_in_byte;
            r_in_eos  <= i_end_of_string;
        end
    end

    // Parser state; end of string returns everything to reset values
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (fire && r_in_eos)) begin
            r_mode <= MODE_TEXT;
            r_hex  <= '0;
            r_dcnt <= '0;
            r_hsur <= '0;
            r_saw  <= 1'b0;
            r_err  <= ST_OK;
            r_utf8 <= '0;
        end else if (fire) begin
            r_mode <= n_mode;
            r_hex  <= n_hex;
            r_dcnt <= n_dcnt;
            r_hsur <= n_hsur;
            r_saw  <= n_saw;
            r_err  <= n_err;
            r_utf8 <= n_utf8;
        end
    end

    // Result bundle register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rvld <= 1'b0;
            r_ridx <= 2'd0;
            r_rcnt <= 2'd0;
        end else if (fire && res_n != 3'd0) begin
            r_rvld <= 1'b1;
            r_ridx <= 2'd0;
            r_rcnt <= 2'(res_n - 3'd1);
        end else if (out_xfer) begin
            if (r_ridx == r_rcnt) r_rvld <= 1'b0;
            else r_ridx <= r_ridx + 2'd1;
        end
        if (fire && res_n != 3'd0) begin
            r_rb    <= em_b;
            r_rbv   <= (em_n != 3'd0);
            r_rlast <= r_in_eos;
            r_rstat <= n_err;
        end
    end

    // Output selection
    assign o_out_valid  = r_rvld;
    assign o_out_byte   = r_rb[r_ridx];
    assign o_byte_valid = r_rbv;
    assign o_last       = r_rlast && (r_ridx == r_rcnt);
    assign o_status     = o_last ? r_rstat : ST_OK;

    // Checks
    a_status_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_byte_valid) |-> o_last)
        else $error("status-only result not marked last");

    a_status_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_last) |-> (o_status == ST_OK))
        else $error("nonzero status on a result that is not last");

    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rvld |-> (r_ridx <= r_rcnt))
        else $error("bundle index beyond bundle size");

    a_err_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && r_err != ST_OK) |-> (em_n == 3'd0))
        else $error("byte emitted after a sticky error");

    a_bundle_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_xfer && r_ridx != r_rcnt && !(fire && res_n != 3'd0)) |=>
        (r_rvld && r_ridx == $past(r_ridx) + 2'd1))
        else $error("bundle did not advance after a transfer");

endmodule
